FILE: rtl/gbn_pkg.sv
package gbn_pkg;

   // default store depth
   localparam int MAX_KEPT = 64;

   // threshold after reset, about 0.45 in Q0.16
   localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

   // one stored box, packed as x, y, width, height from the low end
   typedef struct packed {
      logic [14:0]        h;
      logic [14:0]        w;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } box_type;

   // compare pipeline status toward the sequencer
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } status_type;

   // overlap of two 1-d spans, zero when they do not touch
   function automatic logic [14:0] overlap_len(input logic signed [15:0] a0,
                                               input logic [14:0] alen,
                                               input logic signed [15:0] b0,
                                               input logic [14:0] blen);
      logic signed [17:0] a0_x;
      logic signed [17:0] b0_x;
      logic signed [17:0] lo;
      logic signed [17:0] ea;
      logic signed [17:0] eb;
      logic signed [17:0] hi;
      logic signed [17:0] d;
      a0_x = {{2{a0[15]}}, a0};
      b0_x = {{2{b0[15]}}, b0};
      lo   = (a0_x > b0_x) ? a0_x : b0_x;
      ea   = a0_x + {3'b000, alen};
      eb   = b0_x + {3'b000, blen};
      hi   = (ea < eb) ? ea : eb;
      d    = hi - lo;
      return (hi > lo) ? d[14:0] : 15'd0;
   endfunction

endpackage

FILE: rtl/gbn_iou_unit.sv
module gbn_iou_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  gbn_pkg::box_type       in_box,
   input  gbn_pkg::box_type       a_box,
   input  logic [29:0]            a_area,
   input  logic [15:0]            threshold,
   output gbn_pkg::status_type    status
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [14:0] ox_ff, oy_ff, bw_ff, bh_ff;
   logic [29:0] inter2_ff, area_b_ff;
   logic [29:0] inter3_ff;
   logic [30:0] uni_ff;
   logic [29:0] inter4_ff;
   logic [46:0] prod_ff;
   logic [46:0] inter_scaled;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: overlap along each axis
   always_ff @(posedge clock) begin
      ox_ff <= gbn_pkg::overlap_len(a_box.x, a_box.w, in_box.x, in_box.w);
      oy_ff <= gbn_pkg::overlap_len(a_box.y, a_box.h, in_box.y, in_box.h);
      bw_ff <= in_box.w;
      bh_ff <= in_box.h;
   end

   // stage 2: intersection and stored box area
   always_ff @(posedge clock) begin
      inter2_ff <= ox_ff * oy_ff;
      area_b_ff <= bw_ff * bh_ff;
   end

   // stage 3: union, never negative since intersection fits in both areas
   always_ff @(posedge clock) begin
      uni_ff    <= {1'b0, a_area} + {1'b0, area_b_ff} - {1'b0, inter2_ff};
      inter3_ff <= inter2_ff;
   end

   // stage 4: threshold times union
   always_ff @(posedge clock) begin
      prod_ff   <= threshold * uni_ff;
      inter4_ff <= inter3_ff;
   end

   // cross-multiplied iou test
   assign inter_scaled     = {1'b0, inter4_ff, 16'h0000};
   assign status.hit       = inter_scaled > prod_ff;
   assign status.hit_valid = v4_ff;
   assign status.busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

FILE: rtl/greedy_box_nms.sv
// Greedy non-maximum suppression over boxes that arrive sorted by descending
// score. Each request is compared against every box kept so far in the current
// set by one shared overlap/IoU pipeline that takes one stored box per cycle.
// The response is registered after the store's registered read port, the
// four-stage compare pipeline and a decision step, and a new request is taken
// once the block is back in idle; a stalled response holds the block until it
// is taken. req_stall is high while a request is in work.
// A box is dropped when intersection * 65536 > iou_threshold * union; a kept
// box is appended to the store, and once the store holds MAX_KEPT boxes later
// kept boxes are reported with store_full set and are not stored. first_of_set
// empties the store before its box is handled. The threshold register is
// written through the csr channel and must only be written while no request is
// in flight.
module greedy_box_nms #(
   parameter int MAX_KEPT = gbn_pkg::MAX_KEPT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_of_set,
   input  logic signed [15:0] req_box_x,
   input  logic signed [15:0] req_box_y,
   input  logic [14:0]        req_box_width,
   input  logic [14:0]        req_box_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_keep,
   output logic [5:0]         rsp_kept_slot,
   output logic               rsp_store_full,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_iou_threshold
);

   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                suppress_ff, suppress_in;
   logic [15:0]         thr_ff;
   gbn_pkg::box_type    box_ff;
   logic [29:0]         area_a_ff;
   logic                rd_valid_ff;
   gbn_pkg::box_type    rd_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_keep_ff;
   logic [5:0]          rsp_slot_ff;
   logic                rsp_full_ff;
   gbn_pkg::box_type    kept_mem [MAX_KEPT];
   gbn_pkg::status_type status;

   logic             req_accept;
   logic             issue;
   logic             rsp_free;
   logic             finish;
   logic             keep_now;
   logic             room;
   logic             store;
   logic [CNT_W+5:0] slot_wide;

   // handshake and control terms
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign issue      = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == ST_DRAIN) && !rd_valid_ff && !status.busy
                       && rsp_free;
   assign keep_now   = !suppress_ff;
   assign room       = count_ff < MAX_CNT;
   assign store      = finish && keep_now && room;
   assign slot_wide  = {6'b000000, count_ff};

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      suppress_in = suppress_ff;
      if (status.hit_valid && status.hit) begin
         suppress_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in    = ST_SCAN;
               idx_in      = '0;
               suppress_in = 1'b0;
               if (req_first_of_set) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
               if (store) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         idx_ff      <= '0;
         suppress_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         suppress_ff <= suppress_in;
         rd_valid_ff <= issue;
      end
   end

   // threshold register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbn_pkg::IOU_THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_iou_threshold;
      end
   end

   // current box and its area
   always_ff @(posedge clock) begin
      if (req_accept) begin
         box_ff.x  <= req_box_x;
         box_ff.y  <= req_box_y;
         box_ff.w  <= req_box_width;
         box_ff.h  <= req_box_height;
         area_a_ff <= req_box_width * req_box_height;
      end
   end

   // kept box store, registered read
   always_ff @(posedge clock) begin
      if (store) begin
         kept_mem[count_ff[IDX_W-1:0]] <= box_ff;
      end
      rd_data_ff <= kept_mem[idx_ff[IDX_W-1:0]];
   end

   // shared compare pipeline
   gbn_iou_unit u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_box    (rd_data_ff),
      .a_box     (box_ff),
      .a_area    (area_a_ff),
      .threshold (thr_ff),
      .status    (status)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_keep_ff <= keep_now;
         rsp_slot_ff <= (keep_now && room) ? slot_wide[5:0] : 6'd0;
         rsp_full_ff <= keep_now && !room;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_kept_slot  = rsp_slot_ff;
   assign rsp_store_full = rsp_full_ff;

endmodule

FILE: dv/tb_greedy_box_nms.sv
`timescale 1ns / 1ps

module tb_greedy_box_nms;

   localparam int HOLD_CYCLES      = 300;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PER_PHASE = 155;
   localparam int PHASES           = 12;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_first_of_set;
   logic signed [15:0] req_box_x;
   logic signed [15:0] req_box_y;
   logic [14:0]        req_box_width;
   logic [14:0]        req_box_height;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_keep;
   logic [5:0]         rsp_kept_slot;
   logic               rsp_store_full;
   logic               csr_valid;
   logic               csr_ready;
   logic [15:0]        csr_iou_threshold;

   greedy_box_nms i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_of_set  (req_first_of_set),
      .req_box_x         (req_box_x),
      .req_box_y         (req_box_y),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_keep          (rsp_keep),
      .rsp_kept_slot     (rsp_kept_slot),
      .rsp_store_full    (rsp_store_full),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_iou_threshold (csr_iou_threshold)
   );

   // keeps its own kept list and threshold, predicts one verdict per request
   class suppression_scoreboard;
      typedef struct {
         bit       keep;
         bit [5:0] slot;
         bit       full;
      } verdict_type;

      gbn_pkg::box_type kept_boxes[gbn_pkg::MAX_KEPT];
      int unsigned      kept_count;
      bit [15:0]        threshold;
      verdict_type      verdict_q[$];
      int               errors;
      int               reported;
      int               n_boxes;
      int               n_sets;
      int               n_kept;
      int               n_dropped;
      int               n_full;

      function new();
         kept_count = 0;
         threshold  = gbn_pkg::IOU_THRESHOLD_RESET;
      endfunction

      // overlap of two spans, zero when they do not meet
      function longint span_overlap(longint a0, longint alen, longint b0, longint blen);
         longint lo;
         longint hi;
         lo = (a0 > b0) ? a0 : b0;
         hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
         return (hi > lo) ? hi - lo : 0;
      endfunction

      // greedy iou test against every stored box of the current set
      function void note_box(bit first, logic signed [15:0] x, logic signed [15:0] y,
                             logic [14:0] w, logic [14:0] h);
         gbn_pkg::box_type nb;
         verdict_type      v;
         longint           area;
         longint           inter;
         longint           uni;
         nb.x   = x;
         nb.y   = y;
         nb.w   = w;
         nb.h   = h;
         v.keep = 1'b1;
         v.slot = '0;
         v.full = 1'b0;
         n_boxes++;
         if (first) begin
            kept_count = 0;
            n_sets++;
         end
         area = longint'(w) * longint'(h);
         for (int i = 0; i < kept_count; i++) begin
            inter = span_overlap(longint'(x), longint'(w),
                                 longint'(kept_boxes[i].x), longint'(kept_boxes[i].w)) *
                    span_overlap(longint'(y), longint'(h),
                                 longint'(kept_boxes[i].y), longint'(kept_boxes[i].h));
            uni = area + longint'(kept_boxes[i].w) * longint'(kept_boxes[i].h) - inter;
            if (inter * 65536 > longint'(threshold) * uni) v.keep = 1'b0;
         end
         if (v.keep && kept_count < gbn_pkg::MAX_KEPT) begin
            kept_boxes[kept_count] = nb;
            v.slot = kept_count[5:0];
            kept_count++;
            n_kept++;
         end else if (v.keep) begin
            v.full = 1'b1;
            n_full++;
         end else begin
            n_dropped++;
         end
         verdict_q.insert(verdict_q.size(), v);
      endfunction

      function void report(string field, longint want, longint got);
         errors++;
         if (reported < 60) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end else if (reported == 60) begin
            $display("further mismatches are counted but not shown");
         end
         reported++;
      endfunction

      // compare a response with the oldest pending verdict
      function void check_verdict(bit keep, bit [5:0] slot, bit full);
         verdict_type v;
         if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t ns: response with no request pending, keep %0d slot %0d full %0d",
                     $time, keep, slot, full);
            return;
         end
         v = verdict_q.pop_front();
         if (keep != v.keep) report("keep", v.keep, keep);
         if (slot != v.slot) report("kept_slot", v.slot, slot);
         if (full != v.full) report("store_full", v.full, full);
      endfunction
   endclass

   suppression_scoreboard nms_sb;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_asked;
   int n_settings;

   // clock, 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // monitor: requests feed the predictor, responses get checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            nms_sb.note_box(req_first_of_set, req_box_x, req_box_y, req_box_width,
                            req_box_height);
         end
         if (rsp_valid && !rsp_stall) begin
            nms_sb.check_verdict(rsp_keep, rsp_kept_slot, rsp_store_full);
         end
         if (csr_valid && csr_ready) nms_sb.threshold = csr_iou_threshold;
      end
   end

   // response side: random stall, or a long hold-off when asked
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != holds_done) begin
            holds_done++;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t ns: no transfer for %0d cycles", $time, quiet);
      $display("** greedy_box_nms: FAILED **");
      $finish;
   end

   // one request, with a random gap in front of it
   task automatic send_box(bit first, int xv, int yv, int wv, int hv);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_of_set <= first;
      req_box_x        <= xv[15:0];
      req_box_y        <= yv[15:0];
      req_box_width    <= wv[14:0];
      req_box_height   <= hv[14:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending until every pending verdict has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (nms_sb.verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(bit [15:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_iou_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   function automatic int clamp_len(int v);
      return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
   endfunction

   // boxes scattered around one center, so overlaps land on both sides of the threshold
   task automatic cluster_set(output int n);
      int cx;
      int cy;
      int w0;
      int h0;
      int jx;
      int jy;
      int wv;
      int hv;
      n  = $urandom_range(1, 14);
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      w0 = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 3000);
      h0 = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 3000);
      for (int i = 0; i < n; i++) begin
         jx = int'($urandom_range(0, w0)) - w0 / 2;
         jy = int'($urandom_range(0, h0)) - h0 / 2;
         wv = clamp_len(w0 + int'($urandom_range(0, w0 / 2)) - w0 / 4);
         hv = clamp_len(h0 + int'($urandom_range(0, h0 / 2)) - h0 / 4);
         if ($urandom_range(0, 15) == 0) wv = 0;
         if ($urandom_range(0, 15) == 0) hv = 0;
         send_box(i == 0, cx + jx, cy + jy, wv, hv);
      end
   endtask

   // disjoint boxes on a 9 x 8 grid, enough to fill the store and run past it
   task automatic fill_set(output int n);
      int start;
      int pos;
      n     = $urandom_range(66, 76);
      start = $urandom_range(0, 71);
      for (int i = 0; i < n; i++) begin
         pos = (start + i) % 72;
         send_box(i == 0,
                  -16200 + (pos % 9) * 3600 + int'($urandom_range(0, 400)),
                  -14400 + (pos / 9) * 3600 + int'($urandom_range(0, 400)),
                  $urandom_range(1, 3199), $urandom_range(1, 3199));
      end
   endtask

   task automatic run_random(int quota);
      int done;
      int n;
      int pick;
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 66) begin
            cluster_set(n);
         end else if (pick < 72) begin
            fill_set(n);
         end else begin
            // unstructured noise, any field value
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               send_box($urandom_range(0, 3) == 0, $urandom, $urandom, $urandom, $urandom);
            end
         end
         done += n;
         if ($urandom_range(0, 39) == 0) drain();
      end
   endtask

   // edges of the fields and the named corner cases
   task automatic directed_boxes();
      // reset threshold
      send_box(1, 0, 0, 160, 160);
      send_box(0, 0, 0, 160, 160);
      send_box(0, 1000, 0, 160, 160);
      send_box(0, 160, 0, 160, 160);
      send_box(0, 62, 0, 160, 160);
      send_box(0, 0, 0, 0, 160);
      send_box(0, 0, 0, 160, 0);
      send_box(0, 0, 0, 0, 0);
      send_box(0, 0, 0, 0, 0);
      send_box(0, -32768, -32768, 32767, 32767);
      send_box(0, 32767, 32767, 32767, 32767);
      send_box(0, 32766, 32767, 32767, 32767);
      send_box(1, 21845, -21846, 10922, 21845);
      // zero threshold: any overlap suppresses
      write_threshold(16'd0);
      send_box(1, 0, 0, 160, 160);
      send_box(0, 159, 159, 160, 160);
      send_box(0, 320, 0, 160, 160);
      send_box(0, 0, 0, 0, 0);
      // top threshold: only an identical box suppresses
      write_threshold(16'd65535);
      send_box(1, 0, 0, 160, 160);
      send_box(0, 0, 0, 160, 160);
      send_box(0, 1, 0, 160, 160);
      send_box(0, 0, 0, 160, 161);
   endtask

   initial begin
      bit [15:0] settings[PHASES];
      nms_sb            = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_first_of_set  = 1'b0;
      req_box_x         = '0;
      req_box_y         = '0;
      req_box_width     = '0;
      req_box_height    = '0;
      csr_valid         = 1'b0;
      csr_iou_threshold = '0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      hold_asked        = 0;
      n_settings        = 0;
      settings = '{16'd0, 16'd65535, gbn_pkg::IOU_THRESHOLD_RESET, 16'd32768,
                   16'd1, 16'd65534, 16'd0, 16'd0, 16'd6554, 16'd52428,
                   16'd0, 16'd45875};
      settings[6]  = 16'($urandom_range(0, 65535));
      settings[7]  = 16'($urandom_range(0, 65535));
      settings[10] = 16'($urandom_range(0, 65535));
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_boxes();

      // three idle profiles, four thresholds each
      for (int p = 0; p < PHASES; p++) begin
         case (p / 4)
            0: begin
               send_idle_pct = 34;
               rsp_stall_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               rsp_stall_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_threshold(settings[p]);
         if (p % 4 == 1) hold_asked++;
         run_random(RANDOM_PER_PHASE);
      end

      drain();
      repeat (40) @(posedge clock);

      $display("covered %0d boxes in %0d sets over %0d threshold settings",
               nms_sb.n_boxes, nms_sb.n_sets, n_settings);
      $display("%0d kept, %0d suppressed, %0d kept with the store full",
               nms_sb.n_kept, nms_sb.n_dropped, nms_sb.n_full);
      if (nms_sb.errors == 0) begin
         $display("** greedy_box_nms: PASSED **");
      end else begin
         $display("** greedy_box_nms: FAILED **");
      end
      $finish;
   end

endmodule
